// File: hw/rtl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 engine package
// Shared constants, command and status types and a helper function for the
// SHA-1 controller and datapath.
// ----------------------------------------------------------------------------
package sha1_pkg;

  // Input command codes.
  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Digest geometry.
  localparam int DIGEST_WORDS = 5;
  localparam int IDX_W        = 3;
  localparam int POS_W        = 6;
  localparam int ROUND_W      = 7;
  localparam int BLOCK_BITS   = 512;

  // Initial chaining value.
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  // Round constants.
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  // Padding marker byte.
  localparam logic [7:0] PAD_MARK = 8'h80;

  // Byte source for the block shift line.
  localparam logic [1:0] SEL_DATA = 2'd0;
  localparam logic [1:0] SEL_MARK = 2'd1;
  localparam logic [1:0] SEL_ZERO = 2'd2;
  localparam logic [1:0] SEL_LEN  = 2'd3;

  // Round groups of twenty rounds each.
  localparam logic [1:0] GRP_CH     = 2'd0;
  localparam logic [1:0] GRP_PAR1   = 2'd1;
  localparam logic [1:0] GRP_MAJ    = 2'd2;
  localparam logic [1:0] GRP_PAR2   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                    shift_en;
    logic [1:0]              byte_sel;
    logic                    count_inc;
    logic                    load_work;
    logic                    round_en;
    logic [1:0]              round_grp;
    logic                    update;
    logic                    init;
    logic [IDX_W-1:0]        word_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [POS_W-1:0] pos;
  } status_t;

  // Rotate a 32-bit word left by a constant amount.
  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    rol32 = (x << n) | (x >> (32 - n));
  endfunction

endpackage

// File: hw/rtl/sha1_hash_engine_unit.sv
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Streaming SHA-1: absorbs one message byte per input word and, on a finish
// word, pads the message, runs the last compressions and returns the digest.
// ----------------------------------------------------------------------------
//   Channel  Handshake            Payload
//   input    in_valid / in_ready  command, data_byte
//   output   out_valid/out_ready  digest_word, word_index, last_word
//
// The byte that fills a block also starts the 80 rounds (one per cycle in the
// shared round unit) and then the chaining update.
// A finish pads one byte per cycle through the block shift line, compresses
// once or twice, then offers the five digest words one per accepted cycle.
// Reset loads the initial chaining value and clears the count. The input is
// held off while rounds, the update, padding or digest output are in progress.
module sha1_hash_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha1_pkg::*;

  cmd_t    cmd;
  status_t status;

  sha1_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .word_index (word_index),
    .last_word  (last_word),
    .status     (status),
    .cmd        (cmd)
  );

  sha1_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .cmd         (cmd),
    .status      (status),
    .digest_word (digest_word)
  );

endmodule

// File: hw/rtl/sha1_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-1 controller
// State machine that sequences absorbs, padding, the 80 compression rounds,
// the chaining update and the digest word output.
// ----------------------------------------------------------------------------
module sha1_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             command,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       word_index,
  output logic             last_word,
  input  sha1_pkg::status_t status,
  output sha1_pkg::cmd_t   cmd
);
  import sha1_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PAD    = 3'd1;
  localparam logic [2:0] ST_ROUND  = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(63);
  localparam logic [POS_W-1:0]   POS_LEN   = POS_W'(56);
  localparam logic [ROUND_W-1:0] RND_LAST  = ROUND_W'(79);
  localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(DIGEST_WORDS - 1);

  logic [2:0]         state, state_next;
  logic [ROUND_W-1:0] rnd, rnd_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic               fin, fin_next;
  logic               len_ok, len_ok_next;
  logic               block_full;
  logic               in_acc;

  assign block_full = (status.pos == POS_LAST);
  assign in_ready   = (state == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign out_valid  = (state == ST_EMIT);
  assign word_index = idx;
  assign last_word  = (idx == IDX_LAST);

  // Next-state and command decode.
  always_comb begin
    state_next  = state;
    rnd_next    = rnd;
    idx_next    = idx;
    fin_next    = fin;
    len_ok_next = len_ok;
    cmd         = '0;
    cmd.word_sel = idx;
    if (rnd < ROUND_W'(20)) begin
      cmd.round_grp = GRP_CH;
    end else if (rnd < ROUND_W'(40)) begin
      cmd.round_grp = GRP_PAR1;
    end else if (rnd < ROUND_W'(60)) begin
      cmd.round_grp = GRP_MAJ;
    end else begin
      cmd.round_grp = GRP_PAR2;
    end
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          cmd.shift_en = 1'b1;
          if (command == CMD_ABSORB) begin
            cmd.byte_sel  = SEL_DATA;
            cmd.count_inc = 1'b1;
            if (block_full) begin
              cmd.load_work = 1'b1;
              state_next    = ST_ROUND;
            end
          end else begin
            // The marker byte goes in now; the length may need one more block.
            cmd.byte_sel = SEL_MARK;
            fin_next     = 1'b1;
            if (block_full) begin
              len_ok_next   = 1'b0;
              cmd.load_work = 1'b1;
              state_next    = ST_ROUND;
            end else begin
              len_ok_next = (status.pos < POS_LEN);
              state_next  = ST_PAD;
            end
          end
        end
      end
      ST_PAD: begin
        cmd.shift_en = 1'b1;
        cmd.byte_sel = (len_ok && status.pos >= POS_LEN) ? SEL_LEN : SEL_ZERO;
        if (block_full) begin
          cmd.load_work = 1'b1;
          state_next    = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (rnd == RND_LAST) begin
          rnd_next   = '0;
          state_next = ST_UPDATE;
        end else begin
          rnd_next = rnd + ROUND_W'(1);
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        if (!fin) begin
          state_next = ST_IDLE;
        end else if (!len_ok) begin
          len_ok_next = 1'b1;
          state_next  = ST_PAD;
        end else begin
          idx_next   = '0;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (idx == IDX_LAST) begin
            cmd.init   = 1'b1;
            fin_next   = 1'b0;
            idx_next   = '0;
            state_next = ST_IDLE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rnd    <= '0;
      idx    <= '0;
      fin    <= 1'b0;
      len_ok <= 1'b0;
    end else begin
      state  <= state_next;
      rnd    <= rnd_next;
      idx    <= idx_next;
      fin    <= fin_next;
      len_ok <= len_ok_next;
    end
  end

endmodule

// File: hw/rtl/sha1_datapath.sv
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Block shift line that doubles as the message schedule window, the round
// working registers, the chaining value and the byte count.
// ----------------------------------------------------------------------------
module sha1_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        data_byte,
  input  sha1_pkg::cmd_t    cmd,
  output sha1_pkg::status_t status,
  output logic [31:0]       digest_word
);
  import sha1_pkg::*;

  logic [BLOCK_BITS-1:0] blk;
  logic [31:0]           h [DIGEST_WORDS];
  logic [31:0]           a, b, c, d, e;
  logic [63:0]           count;
  logic [POS_W-1:0]      pos;

  logic [7:0]            byte_in;
  logic [63:0]           bit_len;
  logic [31:0]           w0, w2, w8, w13, w_new;
  logic [31:0]           f, k, t;

  assign status.pos = pos;
  assign bit_len    = {count[60:0], 3'b000};

  // Byte source for the shift line; the length goes out most significant first.
  always_comb begin
    unique case (cmd.byte_sel)
      SEL_DATA: byte_in = data_byte;
      SEL_MARK: byte_in = PAD_MARK;
      SEL_ZERO: byte_in = 8'h00;
      SEL_LEN:  byte_in = bit_len[(7 - int'(pos[2:0])) * 8 +: 8];
      default:  byte_in = 8'h00;
    endcase
  end

  // Schedule taps: word 0 is the oldest word of the sixteen-word window.
  assign w0    = blk[BLOCK_BITS-1      -: 32];
  assign w2    = blk[BLOCK_BITS-1-2*32 -: 32];
  assign w8    = blk[BLOCK_BITS-1-8*32 -: 32];
  assign w13   = blk[BLOCK_BITS-1-13*32 -: 32];
  assign w_new = rol32(w13 ^ w8 ^ w2 ^ w0, 1);

  // Round function and constant for the current group.
  always_comb begin
    unique case (cmd.round_grp)
      GRP_CH: begin
        f = (b & c) | (~b & d);
        k = K0;
      end
      GRP_PAR1: begin
        f = b ^ c ^ d;
        k = K1;
      end
      GRP_MAJ: begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end
      default: begin
        f = b ^ c ^ d;
        k = K3;
      end
    endcase
  end

  assign t = rol32(a, 5) + f + e + k + w0;

  // Digest word selection for the output.
  always_comb begin
    digest_word = h[0];
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      if (cmd.word_sel == IDX_W'(i)) begin
        digest_word = h[i];
      end
    end
  end

  // Block shift line: bytes enter at the low end, rounds shift whole words.
  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      blk <= {blk[BLOCK_BITS-9:0], byte_in};
    end else if (cmd.round_en) begin
      blk <= {blk[BLOCK_BITS-33:0], w_new};
    end
  end

  // Working registers for the compression rounds.
  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (cmd.round_en) begin
      a <= t;
      b <= a;
      c <= rol32(b, 30);
      d <= c;
      e <= d;
    end
  end

  // Chaining value, byte count and block position.
  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      h[0]  <= IV0;
      h[1]  <= IV1;
      h[2]  <= IV2;
      h[3]  <= IV3;
      h[4]  <= IV4;
      count <= '0;
      pos   <= '0;
    end else begin
      if (cmd.update) begin
        h[0] <= h[0] + a;
        h[1] <= h[1] + b;
        h[2] <= h[2] + c;
        h[3] <= h[3] + d;
        h[4] <= h[4] + e;
      end
      if (cmd.count_inc) begin
        count <= count + 64'd1;
      end
      if (cmd.shift_en) begin
        pos <= pos + POS_W'(1);
      end
    end
  end

endmodule

// File: tb/sv/sha1_digest_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-1 digest checker
// Watches both channels of the hash engine. Every accepted input word is fed
// to a bit-exact SHA-1 predictor, and each finish queues the five expected
// digest words. Every accepted output word is compared against the oldest
// queued word, field by field.
// ----------------------------------------------------------------------------
module sha1_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        command,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last_word,
  output int          fail_count,
  output int          words_pending
);
  import sha1_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_entry_t;

  // Digest words predicted but not yet seen on the output.
  digest_entry_t expected_digest_words[$];

  // Predictor state: chaining value, message length and the open block.
  logic [31:0] hash_state [5];
  logic [63:0] msg_bytes;
  logic [7:0]  block_bytes [64];

  int mismatch_total = 0;
  int open_words     = 0;

  assign fail_count    = mismatch_total;
  assign words_pending = open_words;

  // Left rotation taken from the upper half of a doubled word.
  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    logic [63:0] both;
    both = {x, x} << n;
    return both[63:32];
  endfunction

  // Runs the 80 rounds over the open block and folds them into the state.
  function automatic void fold_block();
    logic [31:0] sched [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++) begin
      sched[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2],
                  block_bytes[4*r+3]};
    end
    for (int r = 16; r < 80; r++) begin
      sched[r] = rotl(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
    end
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = rotl(a, 5) + f + e + k + sched[r];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
  endfunction

  function automatic void restart_message();
    hash_state = '{IV0, IV1, IV2, IV3, IV4};
    msg_bytes  = '0;
  endfunction

  // Applies one accepted input word; a finish queues the whole digest.
  function automatic void apply_input_word(input logic cmd, input logic [7:0] b);
    int unsigned pos;
    logic [63:0] bit_len;
    pos = msg_bytes[5:0];
    if (cmd == CMD_ABSORB) begin
      block_bytes[pos] = b;
      msg_bytes++;
      if (pos == 63) fold_block();
    end else begin
      block_bytes[pos] = PAD_MARK;
      pos++;
      // No room left for the length: close this block and open another.
      if (pos > 56) begin
        while (pos < 64) begin
          block_bytes[pos] = 8'h00;
          pos++;
        end
        fold_block();
        pos = 0;
      end
      while (pos < 56) begin
        block_bytes[pos] = 8'h00;
        pos++;
      end
      bit_len = msg_bytes << 3;
      for (int i = 0; i < 8; i++) begin
        block_bytes[56+i] = bit_len[63-8*i -: 8];
      end
      fold_block();
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        expected_digest_words.push_back('{word: hash_state[i], index: 3'(i),
                                          last: (i == DIGEST_WORDS - 1)});
      end
      restart_message();
    end
  endfunction

  // Compare outgoing words first, then account for the incoming word.
  always @(posedge clk) begin : watch
    digest_entry_t want;
    if (rst) begin
      restart_message();
      expected_digest_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_digest_words.size() == 0) begin
          $error("unexpected digest word: digest_word %h word_index %0d last_word %0b",
                 digest_word, word_index, last_word);
          mismatch_total++;
        end else begin
          want = expected_digest_words.pop_front();
          if (digest_word !== want.word) begin
            $error("digest_word: expected %h, actual %h", want.word, digest_word);
            mismatch_total++;
          end
          if (word_index !== want.index) begin
            $error("word_index: expected %0d, actual %0d", want.index, word_index);
            mismatch_total++;
          end
          if (last_word !== want.last) begin
            $error("last_word: expected %0b, actual %0b", want.last, last_word);
            mismatch_total++;
          end
        end
      end
      if (in_valid && in_ready) apply_input_word(command, data_byte);
    end
    open_words = expected_digest_words.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-1 hash engine testbench
// Streams whole messages into the engine, from a few directed ones (empty
// message, short known text, byte extremes, back-to-back finishes) to random
// messages whose lengths cluster around the padding boundaries. Both sides
// stall at random, and the receiver holds off long enough to back up the
// input. The checker beside the engine predicts and compares the digests.
// ----------------------------------------------------------------------------
module tb_top;
  import sha1_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 300;
  localparam int DIGEST_TARGET = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = CMD_ABSORB;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  int fail_count;
  int words_pending;
  int cycle_count = 0;
  int words_sent = 0;
  int digests_sent = 0;
  bit steady_sender = 1'b0;

  sha1_hash_engine_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  sha1_digest_checker checker_inst (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .digest_word   (digest_word),
    .word_index    (word_index),
    .last_word     (last_word),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sender idle gaps: mostly none or short, now and then long.
  function automatic int unsigned sender_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_sender || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Offers one word and waits until the engine takes it.
  task automatic send_word(input logic cmd, input logic [7:0] b);
    int unsigned gap;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (cmd == CMD_FINISH) digests_sent++;
  endtask

  // Sends a message of len bytes, then the finish word.
  // Fill: 0 random bytes, 1 all zero, 2 all ones.
  task automatic send_message(input int unsigned len, input int unsigned fill);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      case (fill)
        1: b = 8'h00;
        2: b = 8'hFF;
        default: b = 8'($urandom());
      endcase
      send_word(CMD_ABSORB, b);
    end
    send_word(CMD_FINISH, 8'($urandom()));
  endtask

  // Message length: mostly short, often right at a padding boundary.
  function automatic int unsigned message_length();
    int unsigned edge_lens [10] = '{55, 56, 57, 62, 63, 64, 65, 119, 120, 127};
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 20);
    if (r < 9) return edge_lens[$urandom_range(0, 9)];
    return $urandom_range(0, 140);
  endfunction

  // Stimulus and verdict.
  initial begin
    int unsigned fill;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Empty message, then a short known text.
    send_word(CMD_FINISH, 8'hFF);
    send_word(CMD_ABSORB, 8'h61);
    send_word(CMD_ABSORB, 8'h62);
    send_word(CMD_ABSORB, 8'h63);
    send_word(CMD_FINISH, 8'h00);
    // Byte extremes, then finishes back to back.
    send_word(CMD_ABSORB, 8'hFF);
    send_word(CMD_ABSORB, 8'h00);
    send_word(CMD_ABSORB, 8'h80);
    send_word(CMD_FINISH, 8'h55);
    send_word(CMD_FINISH, 8'hAA);
    send_word(CMD_FINISH, 8'h00);

    // Random messages.
    while (words_sent < ITEM_TARGET || digests_sent < DIGEST_TARGET) begin
      if ($urandom_range(0, 3) == 0) steady_sender = ~steady_sender;
      case ($urandom_range(0, 9))
        0: fill = 1;
        1: fill = 2;
        default: fill = 0;
      endcase
      send_message(message_length(), fill);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (words_pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: a long hold-off right after reset so the engine backs up, then
  // random stalls with the odd long hold and stretches of steady readiness.
  initial begin
    int unsigned hold;
    bit steady_receiver;
    hold = 0;
    steady_receiver = 1'b0;
    repeat (10) @(negedge clk);
    repeat (400) @(negedge clk);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) steady_receiver = ~steady_receiver;
      if (hold > 0) begin
        hold--;
      end else if ($urandom_range(0, 999) < 2) begin
        out_ready <= 1'b0;
        hold = $urandom_range(150, 300);
      end else if (steady_receiver || $urandom_range(0, 99) < 65) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end
    end
  end

endmodule

// File: filelist.f
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_ctrl.sv
hw/rtl/sha1_datapath.sv
hw/rtl/sha1_hash_engine_unit.sv
tb/sv/sha1_digest_checker.sv
tb/sv/tb_top.sv
